// ===== sv/pts_pkg.sv =====
// Shared types, codes and constants for the periodic timer slot table.
package pts_pkg;

  localparam int SLOTS_DEF  = 16;
  localparam int RESULT_CAP = 16;
  localparam int FIRE_CNT_W = $clog2(RESULT_CAP + 1);
  localparam logic [FIRE_CNT_W-1:0] FIRE_CAP = FIRE_CNT_W'(RESULT_CAP);

  localparam int NOW_W   = 64;
  localparam int IVAL_W  = 24;
  localparam int PID_W   = 8;
  localparam int SLOT_W  = 4;

  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic CFG_IDX_MIN = 1'b0;
  localparam logic CFG_IDX_MAX = 1'b1;

  localparam logic [IVAL_W-1:0] MIN_INTERVAL_RST = 24'd10;
  localparam logic [IVAL_W-1:0] MAX_INTERVAL_RST = 24'd1000000;

  localparam logic [1:0] OP_REGISTER   = 2'd0;
  localparam logic [1:0] OP_UNREGISTER = 2'd1;
  localparam logic [1:0] OP_TICK       = 2'd2;

  localparam logic [1:0] STATUS_DONE    = 2'd0;
  localparam logic [1:0] STATUS_FAIL    = 2'd1;
  localparam logic [1:0] STATUS_FIRED   = 2'd2;
  localparam logic [1:0] STATUS_NOTHING = 2'd3;

  typedef struct packed {
    logic [1:0]        operation;
    logic [NOW_W-1:0]  now_us;
    logic [PID_W-1:0]  owner_pid;
    logic [IVAL_W-1:0] interval;
  } req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic [SLOT_W-1:0] slot;
    logic [PID_W-1:0]  fired_pid;
    logic              last;
  } rsp_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic load;
    logic scan;
    logic flush;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_end;
  } dp_stat_t;

endpackage

// ===== sv/pts_cfg.sv =====
// APB configuration registers: interval limits.
module pts_cfg (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             psel,
  input  logic                             penable,
  input  logic                             pwrite,
  input  logic [pts_pkg::CFG_ADDR_W-1:0]   paddr,
  input  logic [pts_pkg::CFG_DATA_W-1:0]   pwdata,
  output logic [pts_pkg::CFG_DATA_W-1:0]   prdata,
  output logic                             pready,
  output logic [pts_pkg::IVAL_W-1:0]       min_interval,
  output logic [pts_pkg::IVAL_W-1:0]       max_interval
);
  import pts_pkg::*;

  logic       wr_en;
  logic       reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      min_interval <= MIN_INTERVAL_RST;
      max_interval <= MAX_INTERVAL_RST;
    end else if (wr_en) begin
      unique case (reg_idx)
        CFG_IDX_MIN: min_interval <= pwdata[IVAL_W-1:0];
        CFG_IDX_MAX: max_interval <= pwdata[IVAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      CFG_IDX_MIN: prdata = CFG_DATA_W'(min_interval);
      CFG_IDX_MAX: prdata = CFG_DATA_W'(max_interval);
      default:     prdata = '0;
    endcase
  end

endmodule

// ===== sv/pts_ctrl.sv =====
// Controller: sequences load, slot scan and final result.
module pts_ctrl (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  output pts_pkg::dp_cmd_t  cmd,
  input  pts_pkg::dp_stat_t stat
);
  import pts_pkg::*;

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    busy       = 1'b1;
    unique case (state)
      ST_IDLE: begin
        busy = 1'b0;
        if (start) begin
          cmd.load   = 1'b1;
          state_next = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_end) begin
          state_next = ST_FLUSH;
        end
      end
      ST_FLUSH: begin
        cmd.flush  = 1'b1;
        state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

endmodule

// ===== sv/pts_dp.sv =====
// Datapath: slot memories, active bits, scan pipeline and result register.
module pts_dp #(
  parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
  input  logic                       clk,
  input  logic                       rst,
  input  pts_pkg::req_t              req,
  input  logic [pts_pkg::IVAL_W-1:0] min_interval,
  input  logic [pts_pkg::IVAL_W-1:0] max_interval,
  input  pts_pkg::dp_cmd_t           cmd,
  output pts_pkg::dp_stat_t          stat,
  output pts_pkg::rsp_t              result,
  output logic                       result_valid
);
  import pts_pkg::*;

  localparam int IW = $clog2(SLOTS);
  localparam int CW = $clog2(SLOTS + 1);
  localparam logic [CW-1:0] SCAN_LEN = CW'(SLOTS);
  localparam logic [IW-1:0] LAST_IDX = IW'(SLOTS - 1);

  logic [PID_W-1:0]  owner_mem  [SLOTS];
  logic [IVAL_W-1:0] period_mem [SLOTS];
  logic [NOW_W-1:0]  due_mem    [SLOTS];
  logic [SLOTS-1:0]  active;

  // latched transaction
  logic [1:0]        op;
  logic [NOW_W-1:0]  now;
  logic [PID_W-1:0]  pid;
  logic [IVAL_W-1:0] ival;
  logic [NOW_W-1:0]  reg_due;
  logic              in_range;

  // scan pipeline
  logic [CW-1:0]     rd_idx;
  logic [IW-1:0]     rd_addr;
  logic              rd_more;
  logic              rd_en;
  logic              ev_valid;
  logic [IW-1:0]     ev_idx;
  logic [PID_W-1:0]  owner_rd;
  logic [IVAL_W-1:0] period_rd;
  logic [NOW_W-1:0]  due_rd;

  logic [FIRE_CNT_W-1:0] fire_cnt;
  logic                  pend_valid;
  logic [1:0]            pend_status;
  logic [SLOT_W-1:0]     pend_slot;
  logic [PID_W-1:0]      pend_pid;

  logic              act;
  logic              hit;
  logic              fire;
  logic              is_reg;
  logic [SLOT_W-1:0] ev_slot;
  logic              due_wr_en;
  logic [NOW_W-1:0]  due_wr_data;
  logic              emit;
  rsp_t              rsp_next;

  assign rd_addr = rd_idx[IW-1:0];
  assign rd_more = (rd_idx != SCAN_LEN);
  assign rd_en   = cmd.scan && rd_more;
  assign ev_slot = SLOT_W'(ev_idx);
  assign is_reg  = (op == OP_REGISTER);
  assign act     = active[ev_idx];

  assign hit  = ev_valid && !pend_valid &&
                ((is_reg && in_range && !act) ||
                 (op == OP_UNREGISTER && act && owner_rd == pid));
  assign fire = ev_valid && (op == OP_TICK) && act && (due_rd <= now) &&
                (fire_cnt != FIRE_CAP);

  assign stat.scan_end = ev_valid && (ev_idx == LAST_IDX);

  assign due_wr_en   = (hit && is_reg) || fire;
  assign due_wr_data = fire ? (due_rd + NOW_W'(period_rd)) : reg_due;

  assign emit = (fire && pend_valid) || cmd.flush;

  always_comb begin
    rsp_next = '{status: STATUS_FAIL, slot: '0, fired_pid: '0, last: 1'b1};
    if (cmd.flush) begin
      if (pend_valid) begin
        rsp_next = '{status: pend_status, slot: pend_slot, fired_pid: pend_pid, last: 1'b1};
      end else if (op == OP_TICK) begin
        rsp_next.status = STATUS_NOTHING;
      end
    end else begin
      rsp_next = '{status: pend_status, slot: pend_slot, fired_pid: pend_pid, last: 1'b0};
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= '0;
      rd_idx       <= '0;
      ev_valid     <= 1'b0;
      pend_valid   <= 1'b0;
      fire_cnt     <= '0;
      result_valid <= 1'b0;
    end else begin
      result_valid <= emit;
      if (cmd.load) begin
        rd_idx     <= '0;
        ev_valid   <= 1'b0;
        pend_valid <= 1'b0;
        fire_cnt   <= '0;
      end else begin
        ev_valid <= rd_en;
        if (rd_en) begin
          rd_idx <= rd_idx + 1'b1;
        end
        if (hit) begin
          active[ev_idx] <= is_reg;
        end
        if (hit || fire) begin
          pend_valid <= 1'b1;
        end
        if (fire) begin
          fire_cnt <= fire_cnt + 1'b1;
        end
        if (cmd.flush) begin
          pend_valid <= 1'b0;
        end
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op       <= req.operation;
      now      <= req.now_us;
      pid      <= req.owner_pid;
      ival     <= req.interval;
      reg_due  <= req.now_us + NOW_W'(req.interval);
      in_range <= (req.interval >= min_interval) && (req.interval <= max_interval);
    end
    if (rd_en) begin
      ev_idx <= rd_addr;
    end
    if (hit) begin
      pend_status <= STATUS_DONE;
      pend_slot   <= ev_slot;
      pend_pid    <= '0;
    end else if (fire) begin
      pend_status <= STATUS_FIRED;
      pend_slot   <= ev_slot;
      pend_pid    <= owner_rd;
    end
    if (emit) begin
      result <= rsp_next;
    end
  end

  // slot memories
  always_ff @(posedge clk) begin
    if (hit && is_reg) begin
      owner_mem[ev_idx]  <= pid;
      period_mem[ev_idx] <= ival;
    end
    if (due_wr_en) begin
      due_mem[ev_idx] <= due_wr_data;
    end
    if (rd_en) begin
      owner_rd  <= owner_mem[rd_addr];
      period_rd <= period_mem[rd_addr];
      due_rd    <= due_mem[rd_addr];
    end
  end

endmodule

// ===== sv/periodic_timer_slot_table_top.sv =====
// Periodic timer slot table: every item scans all SLOTS slots, one per cycle.
// The final result strobes after the scan and flush; fired results may come earlier.
// busy stays high through the scan and flush states and the next start is taken back in idle,
// so a new transaction is taken only after the last is through; the one-per-cycle slot scan sets the pace.
// Synchronous reset clears all slots to inactive and loads the interval limits to 10 and 1000000.
// Results are strobed for one cycle each; the receiver cannot stall.
module periodic_timer_slot_table_top #(
  parameter int SLOTS = pts_pkg::SLOTS_DEF
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  pts_pkg::req_t                  req,
  output pts_pkg::rsp_t                  result,
  output logic                           result_valid,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [pts_pkg::CFG_ADDR_W-1:0] paddr,
  input  logic [pts_pkg::CFG_DATA_W-1:0] pwdata,
  output logic [pts_pkg::CFG_DATA_W-1:0] prdata,
  output logic                           pready
);
  import pts_pkg::*;

  logic [IVAL_W-1:0] min_interval;
  logic [IVAL_W-1:0] max_interval;
  dp_cmd_t           cmd;
  dp_stat_t          stat;

  pts_cfg u_cfg (
    .clk          (clk),
    .rst          (rst),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready),
    .min_interval (min_interval),
    .max_interval (max_interval)
  );

  pts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd),
    .stat  (stat)
  );

  pts_dp #(
    .SLOTS (SLOTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .req          (req),
    .min_interval (min_interval),
    .max_interval (max_interval),
    .cmd          (cmd),
    .stat         (stat),
    .result       (result),
    .result_valid (result_valid)
  );

endmodule

// ===== verif/periodic_timer_slot_table_top_test.sv =====
// Self-checking testbench for the periodic timer slot table: directed table, then random phases.
`timescale 1ns / 1ps

module periodic_timer_slot_table_top_test;
  import pts_pkg::*;

  localparam int SLOTS = SLOTS_DEF;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_ADDR_W-1:0] ADDR_MIN = {CFG_IDX_MIN, 2'b00};
  localparam logic [CFG_ADDR_W-1:0] ADDR_MAX = {CFG_IDX_MAX, 2'b00};

  typedef struct {
    req_t r;
    bit   typed;
    rsp_t want;
  } step_row_t;

  logic                  clk;
  logic                  rst;
  logic                  start;
  logic                  busy;
  req_t                  req;
  rsp_t                  result;
  logic                  result_valid;
  logic                  psel;
  logic                  penable;
  logic                  pwrite;
  logic [CFG_ADDR_W-1:0] paddr;
  logic [CFG_DATA_W-1:0] pwdata;
  logic [CFG_DATA_W-1:0] prdata;
  logic                  pready;

  periodic_timer_slot_table_top #(.SLOTS(SLOTS)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .req(req),
    .result(result), .result_valid(result_valid),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  // timer table shadow
  bit                tbl_active [SLOTS];
  logic [PID_W-1:0]  tbl_owner  [SLOTS];
  logic [IVAL_W-1:0] tbl_period [SLOTS];
  logic [NOW_W-1:0]  tbl_due    [SLOTS];
  logic [IVAL_W-1:0] lim_min = MIN_INTERVAL_RST;
  logic [IVAL_W-1:0] lim_max = MAX_INTERVAL_RST;

  rsp_t item_rsps[$];
  rsp_t expected_rsps[$];
  step_row_t plan[$];

  logic [NOW_W-1:0] clock_us = '0;
  int errors = 0;
  int items_sent = 0;
  int results_checked = 0;
  int fires_seen = 0;
  int nothing_seen = 0;
  int fails_seen = 0;
  int burst_left = 0;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #5_000_000;
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

  function automatic rsp_t mk_rsp(logic [1:0] st, logic [SLOT_W-1:0] sl,
                                  logic [PID_W-1:0] pid, logic lst);
    rsp_t o;
    o.status = st;
    o.slot = sl;
    o.fired_pid = pid;
    o.last = lst;
    return o;
  endfunction

  function automatic step_row_t row(logic [1:0] op, logic [NOW_W-1:0] now,
                                    logic [PID_W-1:0] pid, logic [IVAL_W-1:0] ival,
                                    bit typed, logic [1:0] st, logic [SLOT_W-1:0] sl);
    step_row_t s;
    s.r.operation = op;
    s.r.now_us = now;
    s.r.owner_pid = pid;
    s.r.interval = ival;
    s.typed = typed;
    s.want = mk_rsp(st, sl, '0, 1'b1);
    return s;
  endfunction

  // Updates the shadow table and leaves this transaction's results in item_rsps.
  function automatic void timer_table_step(req_t r);
    int n;
    bit hit;
    item_rsps.delete();
    hit = 1'b0;
    case (r.operation)
      OP_REGISTER: begin
        if (r.interval >= lim_min && r.interval <= lim_max) begin
          for (int i = 0; i < SLOTS; i++) begin
            if (!tbl_active[i]) begin
              tbl_active[i] = 1'b1;
              tbl_owner[i] = r.owner_pid;
              tbl_period[i] = r.interval;
              tbl_due[i] = r.now_us + NOW_W'(r.interval);
              item_rsps.push_back(mk_rsp(STATUS_DONE, SLOT_W'(i), '0, 1'b1));
              hit = 1'b1;
              break;
            end
          end
        end
        if (!hit) item_rsps.push_back(mk_rsp(STATUS_FAIL, '0, '0, 1'b1));
      end
      OP_UNREGISTER: begin
        for (int i = 0; i < SLOTS; i++) begin
          if (tbl_active[i] && tbl_owner[i] == r.owner_pid) begin
            tbl_active[i] = 1'b0;
            item_rsps.push_back(mk_rsp(STATUS_DONE, SLOT_W'(i), '0, 1'b1));
            hit = 1'b1;
            break;
          end
        end
        if (!hit) item_rsps.push_back(mk_rsp(STATUS_FAIL, '0, '0, 1'b1));
      end
      OP_TICK: begin
        n = 0;
        for (int i = 0; i < SLOTS && n < RESULT_CAP; i++) begin
          if (tbl_active[i] && r.now_us >= tbl_due[i]) begin
            tbl_due[i] = tbl_due[i] + NOW_W'(tbl_period[i]);
            item_rsps.push_back(mk_rsp(STATUS_FIRED, SLOT_W'(i), tbl_owner[i], 1'b0));
            n++;
          end
        end
        if (n == 0) item_rsps.push_back(mk_rsp(STATUS_NOTHING, '0, '0, 1'b1));
        else item_rsps[n-1].last = 1'b1;
      end
      default: item_rsps.push_back(mk_rsp(STATUS_FAIL, '0, '0, 1'b1));
    endcase
  endfunction

  function automatic req_t rand_item();
    req_t r;
    int pick;
    logic [IVAL_W-1:0] span;
    pick = $urandom_range(0, 99);
    if (pick < 40) r.operation = OP_REGISTER;
    else if (pick < 65) r.operation = OP_UNREGISTER;
    else if (pick < 95) r.operation = OP_TICK;
    else r.operation = OP_UNUSED;

    pick = $urandom_range(0, 99);
    if (pick < 3) clock_us = {$urandom, $urandom};
    else if (pick < 6) clock_us = 64'hFFFF_FFFF_FFFF_FFFF - NOW_W'($urandom_range(0, 200));
    else clock_us = clock_us + NOW_W'($urandom_range(0, 40));
    r.now_us = ($urandom_range(0, 99) < 5) ? {$urandom, $urandom} : clock_us;

    r.owner_pid = ($urandom_range(0, 99) < 80) ? PID_W'($urandom_range(0, 7))
                                                : PID_W'($urandom);

    if (lim_min <= lim_max && $urandom_range(0, 99) < 85) begin
      span = lim_max - lim_min;
      if (span > 60) span = 60;
      r.interval = lim_min + IVAL_W'($urandom_range(0, int'(span)));
    end else begin
      case ($urandom_range(0, 3))
        0: r.interval = '0;
        1: r.interval = '1;
        default: r.interval = IVAL_W'($urandom);
      endcase
    end
    return r;
  endfunction

  task automatic report(string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  always @(posedge clk) begin
    rsp_t want;
    if (!rst && result_valid) begin
      if (expected_rsps.size() == 0) begin
        report($sformatf("result with nothing expected: %p", result));
      end else begin
        want = expected_rsps.pop_front();
        results_checked++;
        if (want.status == STATUS_FIRED) fires_seen++;
        if (want.status == STATUS_NOTHING) nothing_seen++;
        if (want.status == STATUS_FAIL) fails_seen++;
        if (result.status !== want.status)
          report($sformatf("status got %0d want %0d", result.status, want.status));
        if (result.slot !== want.slot)
          report($sformatf("slot got %0d want %0d", result.slot, want.slot));
        if (result.fired_pid !== want.fired_pid)
          report($sformatf("fired_pid got %0h want %0h", result.fired_pid, want.fired_pid));
        if (result.last !== want.last)
          report($sformatf("last got %0b want %0b", result.last, want.last));
      end
    end
  end

  // Returns at the edge that accepts the transaction.
  task automatic send_item(req_t r, bit typed, rsp_t want);
    req <= r;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    items_sent++;
    timer_table_step(r);
    if (typed) expected_rsps.push_back(want);
    else foreach (item_rsps[k]) expected_rsps.push_back(item_rsps[k]);
  endtask

  task automatic pace();
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      start <= 1'b0;
      repeat ($urandom_range(1, 30)) @(posedge clk);
      burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 8);
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    while (expected_rsps.size() != 0 || busy) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic cfg_write(logic [CFG_ADDR_W-1:0] addr, logic [IVAL_W-1:0] value);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= {8'($urandom), value};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    if (addr == ADDR_MIN) lim_min = value;
    else lim_max = value;
  endtask

  task automatic run_phase(logic [IVAL_W-1:0] mn, logic [IVAL_W-1:0] mx, int count);
    rsp_t none;
    none = '0;
    drain();
    cfg_write(ADDR_MIN, mn);
    cfg_write(ADDR_MAX, mx);
    repeat (count) begin
      send_item(rand_item(), 1'b0, none);
      pace();
    end
  endtask

  initial begin
    logic [IVAL_W-1:0] rmin;
    start <= 1'b0;
    req <= '0;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    rst <= 1'b1;
    foreach (tbl_active[i]) tbl_active[i] = 1'b0;

    plan.push_back(row(OP_TICK,       64'd0, 8'h00, 24'd0,       1, STATUS_NOTHING, 0));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'h55, 24'd0,       1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'h01, 24'd0,       1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'h01, 24'd9,       1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'h01, 24'd1000001, 1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'h01, 24'hFFFFFF,  1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'hFF, 24'd10,      1, STATUS_DONE, 0));
    plan.push_back(row(OP_REGISTER, 64'hFFFF_FFFF_FFFF_FFF0, 8'h00, 24'd1000000,
                       1, STATUS_DONE, 1));
    plan.push_back(row(OP_UNUSED, 64'hFFFF_FFFF_FFFF_FFFF, 8'hFF, 24'hFFFFFF,
                       1, STATUS_FAIL, 0));
    plan.push_back(row(OP_TICK,       64'd9, 8'h00, 24'd0,       1, STATUS_NOTHING, 0));
    plan.push_back(row(OP_TICK,       64'd10, 8'h00, 24'd0,      0, STATUS_DONE, 0));
    plan.push_back(row(OP_TICK, 64'hFFFF_FFFF_FFFF_FFFF, 8'h00, 24'd0, 0, STATUS_DONE, 0));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'hFF, 24'd0,       1, STATUS_DONE, 0));
    plan.push_back(row(OP_REGISTER,   64'd0, 8'hAA, 24'd500,     1, STATUS_DONE, 0));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'hFF, 24'd0,       1, STATUS_FAIL, 0));
    plan.push_back(row(OP_REGISTER,   64'd5, 8'h00, 24'd10,      1, STATUS_DONE, 2));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'h00, 24'd0,       1, STATUS_DONE, 1));
    plan.push_back(row(OP_TICK,       64'd2000, 8'h00, 24'd0,    0, STATUS_DONE, 0));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'h00, 24'd0,       1, STATUS_DONE, 2));
    plan.push_back(row(OP_UNREGISTER, 64'd0, 8'hAA, 24'd0,       1, STATUS_DONE, 0));

    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (plan[k]) begin
      send_item(plan[k].r, plan[k].typed, plan[k].want);
      pace();
    end

    // zero interval allowed, table fills and every slot fires
    run_phase(24'd0, 24'd3, 70);
    run_phase(24'd1, 24'hFFFFFF, 70);
    run_phase(24'hFFFFFF, 24'hFFFFFF, 40);
    // limits crossed: every register is rejected
    run_phase(24'd500, 24'd100, 30);
    rmin = IVAL_W'($urandom_range(1, 5000));
    run_phase(rmin, rmin + IVAL_W'($urandom_range(0, 100)), 70);
    run_phase(MIN_INTERVAL_RST, MAX_INTERVAL_RST, 70);

    drain();
    repeat (SLOTS + 4) @(posedge clk);
    if (expected_rsps.size() != 0)
      report($sformatf("%0d results never arrived", expected_rsps.size()));

    $display("Ran %0d transactions over seven limit settings; %0d results checked.",
             items_sent, results_checked);
    $display("Timer fires %0d, empty ticks %0d, rejected/not-found/full %0d.",
             fires_seen, nothing_seen, fails_seen);
    if (errors == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/pts_pkg.sv
sv/pts_cfg.sv
sv/pts_ctrl.sv
sv/pts_dp.sv
sv/periodic_timer_slot_table_top.sv
verif/periodic_timer_slot_table_top_test.sv
